// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define TPMC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TPMC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/tpmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tpmc_pkg;

  localparam int MAX_COLORS_DEF = 6;
  localparam int COUNT_BITS_DEF = 16;

  // palette entry registers, fixed by the register map
  localparam int ENTRY_REGS = 6;
  localparam int ENTRY_IW   = 3;
  localparam int ENTRY_W    = 40;

  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;
  localparam int REG_IW = 3;

  localparam logic [REG_IW-1:0] REG_COLOR_COUNT = 3'd0;
  localparam logic [REG_IW-1:0] REG_THRESHOLD   = 3'd1;
  localparam logic [REG_IW-1:0] REG_ENTRY0      = 3'd2;

  localparam logic [2:0]  COLOR_COUNT_RST = 3'd2;
  localparam logic [17:0] THRESHOLD_RST   = 18'd195075;

  typedef logic [ENTRY_W-1:0] entry_t;

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return {8'd0, d} * {8'd0, d};
  endfunction

endpackage

`default_nettype wire

// ===== src/tpmc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tpmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 6
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/tile_palette_majority_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake                         | payload
// ----------+-----------------------------------+-----------------------------------
// pixel in  | start & !busy                     | red, green, blue, last_of_tile
// result    | valid (one cycle, no backpressure)| found, winner_index, winner_*
// config    | psel & penable & pwrite (pready=1)| paddr (8 regs at 8*i), pwdata 64b
//
// A pixel is taken in S_IDLE; S_DIST walks max(n,1) entries (n = active colors, one
// distance per cycle on a single squarer set), then S_READ and S_RMW update its count
// on a match. A last-of-tile pixel adds a vote pass (S_VRD, S_VCMP, one RAM read per
// entry) over all MAX_COLORS entries, then S_CLEAR clears the counts; the result is
// registered from the last vote step. After reset a clearing pass runs with busy high.
module tile_palette_majority_classifier #(
  parameter int MAX_COLORS = tpmc_pkg::MAX_COLORS_DEF,
  parameter int COUNT_BITS = tpmc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tpmc_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [tpmc_pkg::CFG_DW-1:0]   pwdata,
  output logic      [tpmc_pkg::CFG_DW-1:0]   prdata,
  output logic                               pready,
  input  wire logic                          start,
  input  wire logic [7:0]                    red,
  input  wire logic [7:0]                    green,
  input  wire logic [7:0]                    blue,
  input  wire logic                          last_of_tile,
  output logic                               busy,
  output logic                               valid,
  output logic                               found,
  output logic      [2:0]                    winner_index,
  output logic      [7:0]                    winner_red,
  output logic      [7:0]                    winner_green,
  output logic      [7:0]                    winner_blue,
  output logic signed [15:0]                 winner_height
);

  localparam int CW  = $clog2(MAX_COLORS + 1);
  localparam int AW  = $clog2(MAX_COLORS);
  localparam int EIW = tpmc_pkg::ENTRY_IW;
  localparam int RIW = tpmc_pkg::REG_IW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIST  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_RMW   = 3'd3;
  localparam logic [2:0] S_VRD   = 3'd4;
  localparam logic [2:0] S_VCMP  = 3'd5;
  localparam logic [2:0] S_CLEAR = 3'd6;

  localparam logic [CW-1:0] LAST_IDX = CW'(MAX_COLORS - 1);

  // configuration
  logic [2:0]            color_count;
  logic [17:0]           threshold_sq;
  tpmc_pkg::entry_t      entry_reg [tpmc_pkg::ENTRY_REGS];

  // sequencer
  logic [2:0]            state;
  logic [CW-1:0]         idx;
  logic [7:0]            pix_r, pix_g, pix_b;
  logic                  last_r;
  logic [AW-1:0]         best;
  logic [17:0]           best_d;
  logic [COUNT_BITS-1:0] top;
  logic [AW-1:0]         win;

  // count memory
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  logic [CW-1:0]         n_act;
  logic [RIW-1:0]        reg_idx;
  logic                  cfg_wr;
  logic [AW-1:0]         ent_sel;
  tpmc_pkg::entry_t      ent;
  logic [17:0]           cur_d;
  logic                  take;
  logic [17:0]           best_d_f;
  logic [AW-1:0]         best_f;
  logic                  dist_done;
  logic                  match;
  logic                  vote_upd;
  logic [COUNT_BITS-1:0] top_f;
  logic [AW-1:0]         win_f;

  assign pready  = 1'b1;
  assign busy    = (state != S_IDLE);
  assign reg_idx = paddr[tpmc_pkg::CFG_AW-1 -: RIW];
  assign cfg_wr  = psel && penable && pwrite && pready;

  assign n_act = (color_count > 3'(MAX_COLORS)) ? CW'(MAX_COLORS) : CW'(color_count);

  always_comb begin
    case (reg_idx)
      tpmc_pkg::REG_COLOR_COUNT: prdata = 64'(color_count);
      tpmc_pkg::REG_THRESHOLD:   prdata = 64'(threshold_sq);
      default:                   prdata = 64'(entry_reg[EIW'(reg_idx - tpmc_pkg::REG_ENTRY0)]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_count  <= tpmc_pkg::COLOR_COUNT_RST;
      threshold_sq <= tpmc_pkg::THRESHOLD_RST;
      for (int i = 0; i < tpmc_pkg::ENTRY_REGS; i++) begin
        entry_reg[i] <= '0;
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        tpmc_pkg::REG_COLOR_COUNT: color_count  <= pwdata[2:0];
        tpmc_pkg::REG_THRESHOLD:   threshold_sq <= pwdata[17:0];
        default: entry_reg[EIW'(reg_idx - tpmc_pkg::REG_ENTRY0)] <= pwdata[tpmc_pkg::ENTRY_W-1:0];
      endcase
    end
  end

  // one palette read port: distance pass walks idx, the vote end picks the winner
  assign ent_sel = (state == S_VCMP) ? win_f : idx[AW-1:0];
  assign ent     = entry_reg[EIW'(ent_sel)];

  assign cur_d = 18'(tpmc_pkg::sq_diff(ent[23:16], pix_r))
               + 18'(tpmc_pkg::sq_diff(ent[15:8],  pix_g))
               + 18'(tpmc_pkg::sq_diff(ent[7:0],   pix_b));

  assign take      = (idx == '0) || (cur_d < best_d);
  assign best_d_f  = take ? cur_d : best_d;
  assign best_f    = take ? idx[AW-1:0] : best;
  assign dist_done = (({1'b0, idx} + 1'b1) >= {1'b0, n_act});
  assign match     = (n_act != '0) && (best_d_f <= threshold_sq);

  // strictly greater keeps the lowest index on ties
  assign vote_upd = (idx < n_act) && (ram_rdata > top);
  assign top_f    = vote_upd ? ram_rdata : top;
  assign win_f    = vote_upd ? idx[AW-1:0] : win;

  assign ram_raddr = (state == S_VRD) ? idx[AW-1:0] : best;
  assign ram_we    = (state == S_RMW) || (state == S_CLEAR);
  assign ram_waddr = (state == S_RMW) ? best : idx[AW-1:0];
  assign ram_wdata = (state == S_CLEAR) ? '0 :
                     ((ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1);

  tpmc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MAX_COLORS)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= '0;
      valid <= 1'b0;
    end else begin
      valid <= (state == S_VCMP) && (idx == LAST_IDX);
      case (state)
        S_IDLE: begin
          if (start) begin
            pix_r  <= red;
            pix_g  <= green;
            pix_b  <= blue;
            last_r <= last_of_tile;
            idx    <= '0;
            state  <= S_DIST;
          end
        end
        S_DIST: begin
          best_d <= best_d_f;
          best   <= best_f;
          if (dist_done) begin
            idx <= '0;
            if (match) begin
              state <= S_READ;
            end else if (last_r) begin
              state <= S_VRD;
              top   <= '0;
              win   <= '0;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_READ: begin
          state <= S_RMW;
        end
        S_RMW: begin
          if (last_r) begin
            idx   <= '0;
            top   <= '0;
            win   <= '0;
            state <= S_VRD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_VRD: begin
          state <= S_VCMP;
        end
        S_VCMP: begin
          top <= top_f;
          win <= win_f;
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_CLEAR;
            if (top_f != '0) begin
              found         <= 1'b1;
              winner_index  <= 3'(win_f);
              winner_red    <= ent[23:16];
              winner_green  <= ent[15:8];
              winner_blue   <= ent[7:0];
              winner_height <= ent[39:24];
            end else begin
              found         <= 1'b0;
              winner_index  <= '0;
              winner_red    <= '0;
              winner_green  <= '0;
              winner_blue   <= '0;
              winner_height <= '0;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_VRD;
          end
        end
        S_CLEAR: begin
          if (idx == LAST_IDX) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "assert_macros.svh"

  `TPMC_ASSERT(a_valid_after_vote, clk, rst, valid |-> $past(state) == S_VCMP, "result without vote")
  `TPMC_ASSERT(a_notfound_zero, clk, rst, (valid && !found) |-> (winner_index == '0 && winner_height == '0), "not-found result carries data")
  `TPMC_ASSERT(a_rmw_active, clk, rst, (state == S_RMW) |-> (CW'(best) < n_act), "count update on inactive entry")
  `TPMC_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (state == S_CLEAR && !valid), "reset does not start clearing pass")

endmodule

`default_nettype wire

// ===== bench/tb_tile_palette_majority_classifier.sv =====
`timescale 1ns / 1ps

module tb_tile_palette_majority_classifier;

  localparam int NUM_COLORS = tpmc_pkg::MAX_COLORS_DEF;
  localparam int CNT_W = tpmc_pkg::COUNT_BITS_DEF;
  localparam int DW = tpmc_pkg::CFG_DW;
  localparam int RIW = tpmc_pkg::REG_IW;
  // vote + clear + pipeline slack after the last item
  localparam int SETTLE_CYCLES = 40;
  // a run with every item a tile end and long sender gaps stays well under this limit
  localparam longint CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       tile_end;
  } pixel_t;

  typedef struct packed {
    logic        found;
    logic [2:0]  win_idx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] height;
  } tile_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tpmc_pkg::CFG_AW-1:0] paddr = '0;
  logic [DW-1:0] pwdata = '0;
  logic [DW-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic [7:0] red = '0;
  logic [7:0] green = '0;
  logic [7:0] blue = '0;
  logic last_of_tile = 1'b0;
  logic busy;
  logic valid;
  logic found;
  logic [2:0] winner_index;
  logic [7:0] winner_red;
  logic [7:0] winner_green;
  logic [7:0] winner_blue;
  logic signed [15:0] winner_height;

  // palette model state
  logic [2:0]        pal_count;
  logic [17:0]       pal_threshold;
  tpmc_pkg::entry_t  pal_entry [NUM_COLORS];
  logic [CNT_W-1:0]  match_cnt [NUM_COLORS];

  pixel_t       pixel_q[$];
  tile_result_t tile_result_q[$];
  tile_result_t drv_res;
  tile_result_t mon_exp;
  int           sender_idle_pct = 0;
  int           error_count = 0;
  longint       cycle_count = 0;

  tile_palette_majority_classifier i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .start(start),
    .red(red),
    .green(green),
    .blue(blue),
    .last_of_tile(last_of_tile),
    .busy(busy),
    .valid(valid),
    .found(found),
    .winner_index(winner_index),
    .winner_red(winner_red),
    .winner_green(winner_green),
    .winner_blue(winner_blue),
    .winner_height(winner_height)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_tile_palette_majority_classifier failed");
      $finish;
    end
  end

  // Classify one pixel into the running counts; returns 1 when the pixel closes a tile.
  function automatic bit classify_pixel(input pixel_t px, output tile_result_t res);
    int n;
    int best;
    int best_d;
    int d;
    int dr;
    int dg;
    int db;
    bit have;
    logic [CNT_W-1:0] top;
    res = '0;
    n = (pal_count > NUM_COLORS) ? NUM_COLORS : int'(pal_count);
    have = 1'b0;
    best = 0;
    best_d = 0;
    for (int i = 0; i < n; i++) begin
      dr = int'(pal_entry[i][23:16]) - int'(px.red);
      dg = int'(pal_entry[i][15:8]) - int'(px.green);
      db = int'(pal_entry[i][7:0]) - int'(px.blue);
      d = dr * dr + dg * dg + db * db;
      if (!have || d < best_d) begin
        have = 1'b1;
        best_d = d;
        best = i;
      end
    end
    if (have && best_d <= int'(pal_threshold) && match_cnt[best] != '1)
      match_cnt[best] = match_cnt[best] + 1'b1;
    if (!px.tile_end)
      return 1'b0;
    top = '0;
    for (int i = 0; i < n; i++) begin
      if (match_cnt[i] > top) begin
        top = match_cnt[i];
        res.found = 1'b1;
        res.win_idx = 3'(i);
        res.red = pal_entry[i][23:16];
        res.green = pal_entry[i][15:8];
        res.blue = pal_entry[i][7:0];
        res.height = pal_entry[i][39:24];
      end
    end
    for (int i = 0; i < NUM_COLORS; i++)
      match_cnt[i] = '0;
    return 1'b1;
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (classify_pixel(pixel_q[0], drv_res))
          tile_result_q = {tile_result_q, drv_res};
        pixel_q.delete(0);
      end
      if (start && busy) begin
        // hold the item until taken
      end else if (pixel_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        start <= 1'b1;
        red <= pixel_q[0].red;
        green <= pixel_q[0].green;
        blue <= pixel_q[0].blue;
        last_of_tile <= pixel_q[0].tile_end;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && valid) begin
      if (tile_result_q.size() == 0) begin
        $error("result with no tile pending");
        error_count++;
      end else begin
        mon_exp = tile_result_q[0];
        tile_result_q.delete(0);
        if (found !== mon_exp.found) begin
          $error("found: expected %0d, got %0d", mon_exp.found, found);
          error_count++;
        end
        if (winner_index !== mon_exp.win_idx) begin
          $error("winner_index: expected %0d, got %0d", mon_exp.win_idx, winner_index);
          error_count++;
        end
        if (winner_red !== mon_exp.red) begin
          $error("winner_red: expected %0d, got %0d", mon_exp.red, winner_red);
          error_count++;
        end
        if (winner_green !== mon_exp.green) begin
          $error("winner_green: expected %0d, got %0d", mon_exp.green, winner_green);
          error_count++;
        end
        if (winner_blue !== mon_exp.blue) begin
          $error("winner_blue: expected %0d, got %0d", mon_exp.blue, winner_blue);
          error_count++;
        end
        if (winner_height !== mon_exp.height) begin
          $error("winner_height: expected %0d, got %0d", $signed(mon_exp.height),
                 winner_height);
          error_count++;
        end
      end
    end
  end

  // upper pwdata bits carry junk; the block must drop them
  task automatic write_reg(input logic [RIW-1:0] reg_idx, input logic [DW-1:0] value);
    logic [DW-1:0] data;
    data = {$urandom(), $urandom()};
    case (reg_idx)
      tpmc_pkg::REG_COLOR_COUNT: data[2:0] = value[2:0];
      tpmc_pkg::REG_THRESHOLD:   data[17:0] = value[17:0];
      default:                   data[tpmc_pkg::ENTRY_W-1:0] = value[tpmc_pkg::ENTRY_W-1:0];
    endcase
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 3'b000};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_idx)
      tpmc_pkg::REG_COLOR_COUNT: pal_count = data[2:0];
      tpmc_pkg::REG_THRESHOLD:   pal_threshold = data[17:0];
      default: pal_entry[reg_idx - tpmc_pkg::REG_ENTRY0] = data[tpmc_pkg::ENTRY_W-1:0];
    endcase
  endtask

  task automatic write_entry(input int i, input logic [15:0] height, input logic [23:0] rgb);
    write_reg(RIW'(int'(tpmc_pkg::REG_ENTRY0) + i), {24'd0, height, rgb});
  endtask

  task automatic push_px(input int r, input int g, input int b, input bit tile_end);
    pixel_q = {pixel_q, pixel_t'{red: 8'(r), green: 8'(g), blue: 8'(b), tile_end: tile_end}};
  endtask

  task automatic wait_idle();
    while (pixel_q.size() != 0 || start || tile_result_q.size() != 0 || busy)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int jitter(input logic [7:0] ch);
    int v;
    if ($urandom_range(1) == 0)
      return int'(ch);
    v = int'(ch) + int'($urandom_range(24)) - 12;
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  task automatic random_palette();
    logic [23:0] rgb;
    for (int i = 0; i < NUM_COLORS; i++) begin
      case ($urandom_range(5))
        0:       rgb = (i > 0) ? pal_entry[i-1][23:0] : 24'h000000;  // equal-distance tie
        1:       rgb = 24'hffffff;
        default: rgb = 24'($urandom());
      endcase
      write_entry(i, 16'($urandom()), rgb);
    end
  endtask

  // Mostly pixels near a palette color, some anywhere; tiles of 1..12 pixels.
  task automatic queue_tiles(input int n_items);
    pixel_t px;
    tpmc_pkg::entry_t e;
    int left;
    left = $urandom_range(1, 12);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(4) == 0) begin
        px.red = 8'($urandom());
        px.green = 8'($urandom());
        px.blue = 8'($urandom());
      end else begin
        e = pal_entry[$urandom_range(NUM_COLORS - 1)];
        px.red = 8'(jitter(e[23:16]));
        px.green = 8'(jitter(e[15:8]));
        px.blue = 8'(jitter(e[7:0]));
      end
      left--;
      px.tile_end = (left == 0);
      if (left == 0)
        left = $urandom_range(1, 12);
      pixel_q = {pixel_q, px};
    end
  endtask

  initial begin
    int cc;
    int thr;
    pal_count = tpmc_pkg::COLOR_COUNT_RST;
    pal_threshold = tpmc_pkg::THRESHOLD_RST;
    for (int i = 0; i < NUM_COLORS; i++) begin
      pal_entry[i] = '0;
      match_cnt[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    // reset palette: all entries black, full threshold
    push_px(0, 0, 0, 1);
    push_px(255, 255, 255, 1);
    wait_idle();

    write_reg(tpmc_pkg::REG_COLOR_COUNT, 64'd3);
    write_reg(tpmc_pkg::REG_THRESHOLD, 64'd195075);
    write_entry(0, 16'h8000, 24'h000000);
    write_entry(1, 16'h7fff, 24'hffffff);
    write_entry(2, 16'h0001, 24'h000000);
    push_px(0, 0, 0, 0);
    push_px(255, 255, 255, 0);
    push_px(255, 255, 255, 1);
    push_px(0, 0, 0, 1);           // distance tie between 0 and 2
    push_px(0, 0, 0, 0);
    push_px(255, 255, 255, 1);     // vote tie
    push_px(255, 0, 255, 0);
    push_px(0, 255, 0, 1);
    wait_idle();

    write_reg(tpmc_pkg::REG_THRESHOLD, 64'd0);
    push_px(1, 0, 0, 1);           // rejected, nothing found
    push_px(255, 255, 255, 1);
    wait_idle();

    write_reg(tpmc_pkg::REG_COLOR_COUNT, 64'd0);
    push_px(0, 0, 0, 1);
    wait_idle();

    // above the maximum count, then shrink the palette mid-tile
    write_reg(tpmc_pkg::REG_COLOR_COUNT, 64'd7);
    write_reg(tpmc_pkg::REG_THRESHOLD, 64'h3ffff);
    write_entry(3, 16'h1234, 24'h123456);
    write_entry(4, 16'hfedc, 24'habcdef);
    write_entry(5, 16'hfffb, 24'h804020);
    push_px(128, 64, 32, 0);
    push_px(128, 64, 32, 0);
    push_px(171, 205, 239, 1);
    push_px(128, 64, 32, 0);
    wait_idle();
    write_reg(tpmc_pkg::REG_COLOR_COUNT, 64'd2);
    write_reg(tpmc_pkg::REG_THRESHOLD, 64'd0);
    push_px(1, 1, 1, 1);           // entry 5 holds the count but is out of the vote
    wait_idle();
    write_reg(tpmc_pkg::REG_COLOR_COUNT, 64'd1);
    write_reg(tpmc_pkg::REG_THRESHOLD, 64'd195075);
    push_px(200, 200, 200, 1);
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      case (p % 6)
        0:       cc = 6;
        1:       cc = 2;
        2:       cc = 7;
        3:       cc = $urandom_range(7);
        4:       cc = 1;
        default: cc = 0;
      endcase
      case (p % 5)
        0:       thr = 195075;
        1:       thr = 18'h3ffff;
        2:       thr = 0;
        3:       thr = $urandom_range(2000);
        default: thr = $urandom_range(195075);
      endcase
      case (p % 3)
        0:       sender_idle_pct = 0;
        1:       sender_idle_pct = 67;
        default: sender_idle_pct = 22;
      endcase
      write_reg(tpmc_pkg::REG_COLOR_COUNT, DW'(cc));
      write_reg(tpmc_pkg::REG_THRESHOLD, DW'(thr));
      random_palette();
      queue_tiles(200);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("tb_tile_palette_majority_classifier passed");
    end else begin
      $display("tb_tile_palette_majority_classifier failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/tpmc_pkg.sv
src/tpmc_ram.sv
src/tile_palette_majority_classifier.sv
bench/tb_tile_palette_majority_classifier.sv
